// File: rtl/core/fxss_pkg.sv
// Shared constants, types and command/status structs of the framed XY statistics block.
package fxss_pkg;

  localparam int BUFFER_BYTES  = 512;
  localparam int FRACTION_BITS = 8;
  localparam int MAX_FRAMES    = 64;

  localparam int BS_W     = $clog2(BUFFER_BYTES + 1);
  localparam int N_W      = 7;
  localparam int RD_W     = 24;
  localparam int SUM_W    = 30;
  localparam int SQ_W     = 53;
  localparam int PROD_W   = 60;
  localparam int DEN_W    = 33;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int DIV_W    = RAD_W + 2 * FRACTION_BITS;
  localparam int MEAN_W   = 26;
  localparam int SPREAD_W = 29;
  localparam int OUT_W    = 120;

  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_END   = 8'h03;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_TAKE = 2'd1,
    MODE_DONE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_MEAN_X   = 2'd0,
    OP_MEAN_Y   = 2'd1,
    OP_SPREAD_X = 2'd2,
    OP_SPREAD_Y = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic begin_read;
    op_t  op;
    logic prep;
    logic div_start;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_multi;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/framed_xy_sample_statistics.sv
// Top level: framed XY sample statistics over the bytes of one serial read.
//
// Input channel: one received byte per item in in_tdata, in_tlast marks the
// last byte of a read. Ordinary bytes are taken one per cycle while in_tready
// is high; the parser hunts for an 8-byte frame (0x02 ... 0x03), then takes
// aligned frames and sums x, y and their squares.
// The item carrying in_tlast starts the end-of-read pass; in_tready stays low
// until the result is placed in the output register. The pass runs the
// shared bit-serial divider for both means and both spread quotients and the
// shared root unit for the spreads: with no frame it skips both units, with
// one frame it computes only the means, with two or more it computes all four.
// Output channel: one item per read: means, spreads, frame count in out_tdata,
// no-data flag in out_tuser. It sits in an output register, so the bytes of
// the next read are accepted while it waits; a stalled receiver holds back
// only the next end-of-read result.
// Reset (rst_n low, synchronous) clears the parser, the sums and out_tvalid.
module framed_xy_sample_statistics (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tlast,   // end_of_read
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [25:0] mean_x, [51:26] mean_y, [80:52] spread_x, [109:81] spread_y,
  // [116:110] frame_count, [119:117] zero
  output logic [fxss_pkg::OUT_W-1:0]   out_tdata,
  output logic                         out_tuser   // no_data
);

  fxss_pkg::cmd_t  cmd;
  fxss_pkg::stat_t stat;

  fxss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fxss_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_in    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending item");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load_out))
    else $error("out_tvalid rose without a result load");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("no-data item carries nonzero fields");

endmodule

// File: rtl/core/fxss_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module fxss_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [fxss_pkg::DIV_W-1:0]       dividend,
  input  logic [fxss_pkg::DEN_W-1:0]       divisor,
  output logic                             done,
  output logic [fxss_pkg::DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(fxss_pkg::DIV_W + 1);

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [fxss_pkg::DEN_W-1:0]    den_r;
  logic [fxss_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [fxss_pkg::DIV_W-1:0]    quo_r, quo_nxt;
  logic [fxss_pkg::DEN_W:0]      trial;
  logic                          ge;

  always_comb begin
    trial    = {rem_r, quo_r[fxss_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(fxss_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? fxss_pkg::DEN_W'(trial - {1'b0, den_r})
                   : trial[fxss_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[fxss_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/fxss_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module fxss_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fxss_pkg::RAD_W-1:0]    radicand,
  output logic                          done,
  output logic [fxss_pkg::ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(fxss_pkg::ROOT_W + 1);
  localparam int REM_W = fxss_pkg::ROOT_W + 2;

  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [fxss_pkg::RAD_W-1:0]     rad_r, rad_nxt;
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic [fxss_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [REM_W+1:0]               shifted;
  logic [REM_W+1:0]               trial;
  logic                           ge;

  always_comb begin
    shifted  = {rem_r, rad_r[fxss_pkg::RAD_W-1 -: 2]};
    trial    = (REM_W + 2)'({root_r, 2'b01});
    ge       = shifted >= trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(fxss_pkg::ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[fxss_pkg::RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? REM_W'(shifted - trial) : REM_W'(shifted);
      root_nxt = {root_r[fxss_pkg::ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/core/fxss_ctrl.sv
// Controller: byte intake handshake and sequencing of the end-of-read arithmetic.
module fxss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tlast,
  output logic            in_tready,
  input  fxss_pkg::stat_t stat,
  output fxss_pkg::cmd_t  cmd
);

  fxss_pkg::state_t state_r, state_nxt;
  fxss_pkg::op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fxss_pkg::S_IDLE;
      op_r    <= fxss_pkg::OP_MEAN_X;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.op         = op_r;
    case (state_r)
      fxss_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.take_byte = in_tvalid;
        if (in_tvalid && in_tlast) begin
          cmd.begin_read = 1'b1;
          state_nxt      = fxss_pkg::S_CHECK;
        end
      end
      fxss_pkg::S_CHECK: begin
        op_nxt    = fxss_pkg::OP_MEAN_X;
        state_nxt = stat.n_zero ? fxss_pkg::S_LOAD : fxss_pkg::S_PREP;
      end
      fxss_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = fxss_pkg::S_DIV_GO;
      end
      fxss_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = fxss_pkg::S_DIV_WAIT;
      end
      fxss_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          case (op_r)
            fxss_pkg::OP_MEAN_X: begin
              op_nxt    = fxss_pkg::OP_MEAN_Y;
              state_nxt = fxss_pkg::S_PREP;
            end
            fxss_pkg::OP_MEAN_Y: begin
              op_nxt    = fxss_pkg::OP_SPREAD_X;
              state_nxt = stat.n_multi ? fxss_pkg::S_PREP : fxss_pkg::S_LOAD;
            end
            default: state_nxt = fxss_pkg::S_SQRT_GO;
          endcase
        end
      end
      fxss_pkg::S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = fxss_pkg::S_SQRT_WAIT;
      end
      fxss_pkg::S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          if (op_r == fxss_pkg::OP_SPREAD_X) begin
            op_nxt    = fxss_pkg::OP_SPREAD_Y;
            state_nxt = fxss_pkg::S_PREP;
          end else begin
            state_nxt = fxss_pkg::S_LOAD;
          end
        end
      end
      fxss_pkg::S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fxss_pkg::S_IDLE;
        end
      end
      default: state_nxt = fxss_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/fxss_dp.sv
// Datapath: frame parser, accumulators, divider and root units, result register.
module fxss_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  byte_in,
  input  fxss_pkg::cmd_t              cmd,
  output fxss_pkg::stat_t             stat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [fxss_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tuser
);

  // parser and accumulator state
  logic [63:0]                        win_r, win_nxt;
  fxss_pkg::mode_t                    mode_r, mode_nxt;
  logic [2:0]                         phase_r, phase_nxt;
  logic [fxss_pkg::BS_W-1:0]          bytes_r, bytes_nxt;
  logic [fxss_pkg::N_W-1:0]           frames_r, frames_nxt;
  logic signed [fxss_pkg::SUM_W-1:0]  sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [fxss_pkg::SQ_W-1:0]          sq_x_r, sq_x_nxt, sq_y_r, sq_y_nxt;

  logic [63:0]                        shift_win;
  logic                               frame_ok;
  logic                               take;
  logic signed [fxss_pkg::RD_W-1:0]   x_val, y_val;
  logic [fxss_pkg::RD_W-1:0]          x_mag, y_mag;
  logic [2*fxss_pkg::RD_W-1:0]        x_sq, y_sq;

  always_comb begin
    shift_win = {byte_in, win_r[63:8]};
    frame_ok  = (shift_win[7:0] == fxss_pkg::FRAME_START) &&
                (shift_win[63:56] == fxss_pkg::FRAME_END);
    x_val     = signed'(shift_win[31:8]);
    y_val     = signed'(shift_win[55:32]);
    x_mag     = x_val[fxss_pkg::RD_W-1] ? fxss_pkg::RD_W'(-x_val) : x_val;
    y_mag     = y_val[fxss_pkg::RD_W-1] ? fxss_pkg::RD_W'(-y_val) : y_val;
    x_sq      = x_mag * x_mag;
    y_sq      = y_mag * y_mag;

    win_nxt    = win_r;
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    bytes_nxt  = bytes_r;
    take       = 1'b0;
    if (cmd.take_byte && (bytes_r < fxss_pkg::BS_W'(fxss_pkg::BUFFER_BYTES))) begin
      bytes_nxt = bytes_r + 1'b1;
      win_nxt   = shift_win;
      case (mode_r)
        fxss_pkg::MODE_HUNT: begin
          if ((bytes_nxt >= fxss_pkg::BS_W'(8)) && frame_ok) begin
            take      = 1'b1;
            mode_nxt  = fxss_pkg::MODE_TAKE;
            phase_nxt = '0;
          end
        end
        fxss_pkg::MODE_TAKE: begin
          if (phase_r == 3'd7) begin
            phase_nxt = '0;
            if ((frames_r < fxss_pkg::N_W'(fxss_pkg::MAX_FRAMES)) && frame_ok) begin
              take = 1'b1;
            end else begin
              mode_nxt = fxss_pkg::MODE_DONE;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
    frames_nxt = take ? frames_r + 1'b1 : frames_r;
    sum_x_nxt  = take ? sum_x_r + fxss_pkg::SUM_W'(x_val) : sum_x_r;
    sum_y_nxt  = take ? sum_y_r + fxss_pkg::SUM_W'(y_val) : sum_y_r;
    sq_x_nxt   = take ? sq_x_r + fxss_pkg::SQ_W'(x_sq) : sq_x_r;
    sq_y_nxt   = take ? sq_y_r + fxss_pkg::SQ_W'(y_sq) : sq_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      win_r    <= '0;
      mode_r   <= fxss_pkg::MODE_HUNT;
      phase_r  <= '0;
      bytes_r  <= '0;
      frames_r <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sq_x_r   <= '0;
      sq_y_r   <= '0;
    end else begin
      win_r    <= win_nxt;
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      bytes_r  <= bytes_nxt;
      frames_r <= frames_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      sq_x_r   <= sq_x_nxt;
      sq_y_r   <= sq_y_nxt;
    end
  end

  // operand preparation
  logic [fxss_pkg::SUM_W-1:0]   mag_x, mag_y, mag_sel;
  logic [fxss_pkg::PROD_W-1:0]  ns_sel, s2_sel;
  logic [fxss_pkg::N_W-1:0]     k_val;
  logic [13:0]                  kk_r;
  logic [20:0]                  nkk_r;
  logic [fxss_pkg::DEN_W-1:0]   den_spread;
  logic [12:0]                  den_mean;
  logic                         is_mean;
  logic [fxss_pkg::PROD_W-1:0]  p_a_r, p_b_r, diff;
  logic [fxss_pkg::DEN_W-1:0]   den_r;
  logic                         neg_r;
  logic [fxss_pkg::DIV_W-1:0]   dividend;

  always_comb begin
    mag_x      = sum_x_r[fxss_pkg::SUM_W-1] ? fxss_pkg::SUM_W'(-sum_x_r) : sum_x_r;
    mag_y      = sum_y_r[fxss_pkg::SUM_W-1] ? fxss_pkg::SUM_W'(-sum_y_r) : sum_y_r;
    is_mean    = (cmd.op == fxss_pkg::OP_MEAN_X) || (cmd.op == fxss_pkg::OP_MEAN_Y);
    mag_sel    = ((cmd.op == fxss_pkg::OP_MEAN_X) || (cmd.op == fxss_pkg::OP_SPREAD_X))
                 ? mag_x : mag_y;
    k_val      = frames_r - 1'b1;
    den_mean   = frames_r * 7'd100;
    den_spread = nkk_r * 14'd10000;
  end

  assign ns_sel = frames_r *
                  (((cmd.op == fxss_pkg::OP_MEAN_X) || (cmd.op == fxss_pkg::OP_SPREAD_X))
                   ? sq_x_r : sq_y_r);
  assign s2_sel = mag_sel * mag_sel;

  always_ff @(posedge clk) begin
    kk_r  <= k_val * k_val;
    nkk_r <= frames_r * kk_r;
    if (cmd.prep) begin
      neg_r <= ((cmd.op == fxss_pkg::OP_MEAN_X) ? sum_x_r[fxss_pkg::SUM_W-1]
                                                : sum_y_r[fxss_pkg::SUM_W-1]);
      if (is_mean) begin
        p_a_r <= fxss_pkg::PROD_W'(mag_sel);
        p_b_r <= '0;
        den_r <= fxss_pkg::DEN_W'(den_mean);
      end else begin
        p_a_r <= ns_sel;
        p_b_r <= s2_sel;
        den_r <= den_spread;
      end
    end
  end

  always_comb begin
    diff     = (p_a_r > p_b_r) ? p_a_r - p_b_r : '0;
    dividend = is_mean ? (fxss_pkg::DIV_W'(diff) << fxss_pkg::FRACTION_BITS)
                       : (fxss_pkg::DIV_W'(diff) << (2 * fxss_pkg::FRACTION_BITS));
  end

  logic                          div_done;
  logic [fxss_pkg::DIV_W-1:0]    quotient;
  logic [fxss_pkg::RAD_W-1:0]    radicand;
  logic                          sqrt_done;
  logic [fxss_pkg::ROOT_W-1:0]   root;

  fxss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // oversized quotient saturates before the root
  assign radicand = (quotient > fxss_pkg::DIV_W'({fxss_pkg::RAD_W{1'b1}}))
                    ? '1 : quotient[fxss_pkg::RAD_W-1:0];

  fxss_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  // results
  logic [fxss_pkg::MEAN_W-1:0]    mean_x_r, mean_y_r, mean_val;
  logic [fxss_pkg::SPREAD_W-1:0]  spread_x_r, spread_y_r;
  logic                           out_tvalid_r;
  logic [fxss_pkg::OUT_W-1:0]     out_tdata_r;
  logic                           out_tuser_r;

  assign mean_val = neg_r ? fxss_pkg::MEAN_W'(-quotient[fxss_pkg::MEAN_W-1:0])
                          : quotient[fxss_pkg::MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.begin_read) begin
      mean_x_r   <= '0;
      mean_y_r   <= '0;
      spread_x_r <= '0;
      spread_y_r <= '0;
    end else begin
      if (div_done && (cmd.op == fxss_pkg::OP_MEAN_X)) mean_x_r <= mean_val;
      if (div_done && (cmd.op == fxss_pkg::OP_MEAN_Y)) mean_y_r <= mean_val;
      if (sqrt_done && (cmd.op == fxss_pkg::OP_SPREAD_X))
        spread_x_r <= root[fxss_pkg::SPREAD_W-1:0];
      if (sqrt_done && (cmd.op == fxss_pkg::OP_SPREAD_Y))
        spread_y_r <= root[fxss_pkg::SPREAD_W-1:0];
    end
    if (cmd.load_out) begin
      out_tdata_r <= fxss_pkg::OUT_W'({frames_r, spread_y_r, spread_x_r, mean_y_r, mean_x_r});
      out_tuser_r <= (frames_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign stat.n_zero    = (frames_r == '0);
  assign stat.n_multi   = (frames_r >= fxss_pkg::N_W'(2));
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
